[rtl/nbs_pkg.sv]
// Shared types, codes and constants for the NES bank switch mapper.
// No dependencies; imported by nbs_mod_unit and nes_bank_switch_mapper_top.
package nbs_pkg;

    // field widths
    localparam int OP_W      = 2;
    localparam int ADDR_W    = 15;
    localparam int DATA_W    = 8;
    localparam int MAP_W     = 21;
    localparam int IRQ_W     = 16;
    localparam int BANK_W    = 8;
    localparam int CNT_W     = 9;
    localparam int CFG_IDX_W = 1;

    localparam int PRG_SHIFT = 13;
    localparam int CHR_SHIFT = 10;
    localparam int PRG_WINS  = 3;

    localparam int CHR_SLOTS_DEF = 8;

    // bank count ceiling
    localparam logic [CNT_W-1:0] MAX_BANKS = 9'd256;

    // operation codes
    localparam logic [OP_W-1:0] OP_PRG_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_REG_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_CHR_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT = 1'b1;

    // CPU register map
    localparam logic [15:0] REG_PRG0      = 16'h8000;
    localparam logic [15:0] REG_PRG1      = 16'hA000;
    localparam logic [15:0] REG_PRG2      = 16'hC000;
    localparam logic [15:0] REG_CHR_BASE  = 16'hB000;
    localparam logic [15:0] REG_MIRROR    = 16'h9001;
    localparam logic [15:0] REG_IRQ_EN    = 16'h9003;
    localparam logic [15:0] REG_IRQ_LOAD  = 16'h9004;
    localparam logic [15:0] REG_RELOAD_HI = 16'h9005;
    localparam logic [15:0] REG_RELOAD_LO = 16'h9006;

    localparam int FLAG_BIT = 7;

    // request to the shared modulo unit
    typedef struct packed {
        logic              start;
        logic [BANK_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } t_mod_req;

    // response from the shared modulo unit
    typedef struct packed {
        logic              done;
        logic [BANK_W-1:0] remainder;
    } t_mod_rsp;

endpackage

[rtl/nes_bank_switch_mapper_top.sv]
// Top level of the NES bank switch mapper: decode, bank state and sequencer.
// Depends on nbs_pkg and instantiates nbs_mod_unit.
//
// Usage: one bus operation is one transfer on the input channel (operation,
// address, write_data, valid/ready). Program reads map a CPU offset into a
// program ROM address through three switchable 8 KB windows and a fixed last
// window; character reads map a PPU address through eight 1 KB banks; register
// writes update banks, mirroring, interrupt enable and counter. Each operation
// yields exactly one transfer on the output channel, with the status flags as
// they stand after the operation.
// Every operation runs the bit-serial modulo unit over its 8 dividend bits;
// output valid rises once the result is registered. The next item is taken as
// soon as the sequencer is idle, never while one is still being worked on.
// The input is accepted while a previous result still waits; if the receiver
// stalls, the next result holds in the sequencer until the output frees up.
// Reset (synchronous, active low) clears the sequencer, both bank counts and
// sets program banks to 0, 1, 14 and all character banks and flags to zero.
// The user must write the bank counts over the configuration port only while
// idle; the block does not enforce this. Values above 256 saturate to 256.
module nes_bank_switch_mapper_top #(
    parameter int CHR_SLOTS = nbs_pkg::CHR_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [nbs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nbs_pkg::CNT_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [nbs_pkg::OP_W-1:0]       i_operation,
    input  logic [nbs_pkg::ADDR_W-1:0]     i_address,
    input  logic [nbs_pkg::DATA_W-1:0]     i_write_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [nbs_pkg::MAP_W-1:0]      o_mapped_address,
    output logic                           o_no_rom,
    output logic                           o_mirroring_horizontal,
    output logic                           o_irq_enabled,
    output logic [nbs_pkg::IRQ_W-1:0]      o_irq_counter
);
    import nbs_pkg::*;

    localparam int SLOT_W = $clog2(CHR_SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_prg_cnt;
    logic [CNT_W-1:0]  r_chr_cnt;
    logic [BANK_W-1:0] r_prg_bank [PRG_WINS];
    logic [BANK_W-1:0] r_chr_bank [CHR_SLOTS];
    logic              r_mirror;
    logic              r_irq_en;
    logic [IRQ_W-1:0]  r_irq_cnt;
    logic [DATA_W-1:0] r_reload_hi;
    logic [DATA_W-1:0] r_reload_lo;

    logic [OP_W-1:0]   r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_data;

    logic              r_out_valid;
    logic [MAP_W-1:0]  r_mapped;
    logic              r_no_rom;
    logic              r_out_mirror;
    logic              r_out_irq_en;
    logic [IRQ_W-1:0]  r_out_irq_cnt;

    logic [BANK_W-1:0] n_prg_bank [PRG_WINS];
    logic [BANK_W-1:0] n_chr_bank [CHR_SLOTS];
    logic              n_mirror;
    logic              n_irq_en;
    logic [IRQ_W-1:0]  n_irq_cnt;
    logic [DATA_W-1:0] n_reload_hi;
    logic [DATA_W-1:0] n_reload_lo;
    logic [MAP_W-1:0]  n_mapped;
    logic              n_no_rom;
    logic [CNT_W-1:0]  n_cfg_val;

    logic              w_accept;
    logic              w_commit;
    logic              w_in_chr_wr;
    logic [15:0]       w_in_reg;
    logic [15:0]       w_reg;
    logic [BANK_W-1:0] w_red_p;
    logic [BANK_W-1:0] w_red_c;
    logic [BANK_W-1:0] w_bank;
    logic [SLOT_W-1:0] w_slot;
    t_mod_req          w_req;
    t_mod_rsp          w_rsp;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_commit   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // pick modulo operands from the incoming item
    always_comb begin
        w_in_reg    = {1'b1, i_address};
        w_in_chr_wr = (w_in_reg >= REG_CHR_BASE) && (w_in_reg < REG_CHR_BASE + CHR_SLOTS);
        w_req.start = w_accept;
        w_req.dividend = i_write_data;
        if (i_operation == OP_PRG_READ) begin
            case (i_address[ADDR_W-1 -: 2])
                2'd0:    w_req.dividend = r_prg_bank[0];
                2'd1:    w_req.dividend = r_prg_bank[1];
                2'd2:    w_req.dividend = r_prg_bank[2];
                default: w_req.dividend = '0;
            endcase
        end
        w_req.divisor = (i_operation == OP_REG_WRITE && w_in_chr_wr) ? r_chr_cnt : r_prg_cnt;
    end

    nbs_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // saturate configured bank counts
    assign n_cfg_val = (i_cfg_data > MAX_BANKS) ? MAX_BANKS : i_cfg_data;

    // work out next state and result of the held item
    always_comb begin
        w_reg   = {1'b1, r_addr};
        w_red_p = (r_prg_cnt == '0) ? '0 : w_rsp.remainder;
        w_red_c = (r_chr_cnt == '0) ? '0 : w_rsp.remainder;
        w_bank  = (r_addr[ADDR_W-1 -: 2] == 2'd3) ? BANK_W'(r_prg_cnt - 1'b1)
                                                  : w_rsp.remainder;
        w_slot  = r_addr[CHR_SHIFT +: SLOT_W];

        n_prg_bank  = r_prg_bank;
        n_chr_bank  = r_chr_bank;
        n_mirror    = r_mirror;
        n_irq_en    = r_irq_en;
        n_irq_cnt   = r_irq_cnt;
        n_reload_hi = r_reload_hi;
        n_reload_lo = r_reload_lo;
        n_mapped    = '0;
        n_no_rom    = 1'b0;

        case (r_op)
            OP_PRG_READ: begin
                if (r_prg_cnt == '0) begin
                    n_no_rom = 1'b1;
                end else begin
                    n_mapped = MAP_W'({w_bank, r_addr[PRG_SHIFT-1:0]});
                end
            end
            OP_REG_WRITE: begin
                if (w_reg == REG_PRG0) begin
                    n_prg_bank[0] = w_red_p;
                end else if (w_reg == REG_PRG1) begin
                    n_prg_bank[1] = w_red_p;
                end else if (w_reg == REG_PRG2) begin
                    n_prg_bank[2] = w_red_p;
                end else if ((w_reg >= REG_CHR_BASE) &&
                             (w_reg < REG_CHR_BASE + CHR_SLOTS)) begin
                    n_chr_bank[r_addr[SLOT_W-1:0]] = w_red_c;
                end else if (w_reg == REG_MIRROR) begin
                    n_mirror = r_data[FLAG_BIT];
                end else if (w_reg == REG_IRQ_EN) begin
                    n_irq_en = r_data[FLAG_BIT];
                end else if (w_reg == REG_IRQ_LOAD) begin
                    n_irq_cnt = {r_reload_hi, r_reload_lo};
                end else if (w_reg == REG_RELOAD_HI) begin
                    n_reload_hi = r_data;
                end else if (w_reg == REG_RELOAD_LO) begin
                    n_reload_lo = r_data;
                end
            end
            OP_CHR_READ: begin
                n_mapped = MAP_W'({r_chr_bank[w_slot], r_addr[CHR_SHIFT-1:0]});
            end
            default: begin
                n_mapped = '0;
            end
        endcase
    end

    // sequencer, bank state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_prg_cnt     <= '0;
            r_chr_cnt     <= '0;
            r_prg_bank[0] <= 8'd0;
            r_prg_bank[1] <= 8'd1;
            r_prg_bank[2] <= 8'd14;
            for (int i = 0; i < CHR_SLOTS; i++) begin
                r_chr_bank[i] <= '0;
            end
            r_mirror      <= 1'b0;
            r_irq_en      <= 1'b0;
            r_irq_cnt     <= '0;
            r_reload_hi   <= '0;
            r_reload_lo   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PRG_COUNT) begin
                    r_prg_cnt <= n_cfg_val;
                end else if (i_cfg_idx == CFG_CHR_COUNT) begin
                    r_chr_cnt <= n_cfg_val;
                end
            end

            // raise output valid on commit, drop it after the output transfer
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= i_operation;
                        r_addr  <= i_address;
                        r_data  <= i_write_data;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (w_rsp.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_commit) begin
                        r_prg_bank    <= n_prg_bank;
                        r_chr_bank    <= n_chr_bank;
                        r_mirror      <= n_mirror;
                        r_irq_en      <= n_irq_en;
                        r_irq_cnt     <= n_irq_cnt;
                        r_reload_hi   <= n_reload_hi;
                        r_reload_lo   <= n_reload_lo;
                        r_mapped      <= n_mapped;
                        r_no_rom      <= n_no_rom;
                        r_out_mirror  <= n_mirror;
                        r_out_irq_en  <= n_irq_en;
                        r_out_irq_cnt <= n_irq_cnt;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_mapped_address       = r_mapped;
    assign o_no_rom               = r_no_rom;
    assign o_mirroring_horizontal = r_out_mirror;
    assign o_irq_enabled          = r_out_irq_en;
    assign o_irq_counter          = r_out_irq_cnt;

    // the modulo unit only finishes while the sequencer waits for it
    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_CALC))
        else $error("modulo result outside calc state");

    // an accepted transfer always starts the calculation
    a_accept_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CALC))
        else $error("accepted item did not enter calc");

    // a finished item waits while the output is still occupied
    a_hold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("result overwrote a pending output");

    // a missing program ROM never yields an address
    a_no_rom_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_no_rom) |-> (o_mapped_address == '0))
        else $error("no_rom with nonzero address");

endmodule

[rtl/nbs_mod_unit.sv]
// Bit-serial restoring modulo: 8-bit dividend by a 9-bit divisor, one bit a cycle.
// Depends on nbs_pkg for the request and response structs.
module nbs_mod_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nbs_pkg::t_mod_req i_req,
    output nbs_pkg::t_mod_rsp o_rsp
);
    import nbs_pkg::*;

    localparam int STEP_W = $clog2(BANK_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [BANK_W-1:0] r_dvd;
    logic [CNT_W-1:0]  r_dvs;
    logic [CNT_W-1:0]  r_rem;

    logic [CNT_W-1:0]  w_shift;
    logic [CNT_W-1:0]  n_rem;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        w_shift = {r_rem[CNT_W-2:0], r_dvd[BANK_W-1]};
        n_rem   = (w_shift >= r_dvs) ? (w_shift - r_dvs) : w_shift;
    end

    // step the remainder once per cycle while busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(BANK_W - 1);
                r_dvd  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[BANK_W-2:0], 1'b0};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem[BANK_W-1:0];

endmodule
